### design/table_huffman_bit_packer_assert.svh
// Assertion macros for the Huffman bit packer RTL.
// Included by the modules that check their own invariants; expects clk_i and rst_ni in scope.
`ifndef TABLE_HUFFMAN_BIT_PACKER_ASSERT_SVH
`define TABLE_HUFFMAN_BIT_PACKER_ASSERT_SVH

// Condition holds at every clock edge out of reset.
`define THP_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// Same-cycle implication.
`define THP_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define THP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/thp_pkg.sv
// Shared types and constants of the Huffman bit packer.
// No dependencies; imported by every module of the block except thp_ram.
`default_nettype none

package thp_pkg;

  localparam int MAX_CODE_BITS = 15;
  localparam int LEN_W         = 4;
  localparam int CODE_IN_W     = 15;
  localparam int BYTE_BITS     = 8;
  localparam int TABLE_DEPTH   = 257;
  localparam int IDX_W         = 9;
  localparam int TERMINATOR    = 256;
  localparam int ENTRY_W       = MAX_CODE_BITS + LEN_W;

  // Bit accumulator: at most BYTE_BITS-1 bits wait between items.
  localparam int ACC_W       = BYTE_BITS - 1;
  localparam int PEND_W      = $clog2(BYTE_BITS);
  localparam int VAL_W       = ACC_W + MAX_CODE_BITS;
  localparam int BURST_BYTES = (VAL_W + BYTE_BITS - 1) / BYTE_BITS;
  localparam int BURST_W     = BURST_BYTES * BYTE_BITS;
  localparam int TOT_W       = $clog2(VAL_W + 1);
  localparam int SH_W        = $clog2(BURST_W + 1);
  localparam int BCNT_W      = $clog2(BURST_BYTES + 1);

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    CMD_ENCODE = 2'd0,
    CMD_LOAD   = 2'd1,
    CMD_FLUSH  = 2'd2
  } thp_cmd_e;

  // One looked-up code, queued for the packer.
  typedef struct packed {
    logic                     is_flush;
    logic [MAX_CODE_BITS-1:0] code;
    logic [LEN_W-1:0]         len;
  } thp_entry_t;

  typedef struct packed {
    logic       valid;
    thp_entry_t entry;
  } thp_push_t;

endpackage

`default_nettype wire

### design/thp_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module thp_ram #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [DATA_W-1:0]        wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [DATA_W-1:0]        rdata_o
);

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

### design/thp_front.sv
// Front end: accepts transactions, writes table loads, looks up codes.
// Depends on thp_pkg and thp_ram; pushes lookups into the code queue.
`default_nettype none

`include "table_huffman_bit_packer_assert.svh"

module thp_front
  import thp_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire logic [1:0]           cmd_i,
  input  wire logic [7:0]           data_byte_i,
  input  wire logic [IDX_W-1:0]     entry_index_i,
  input  wire logic [CODE_IN_W-1:0] entry_code_i,
  input  wire logic [LEN_W-1:0]     entry_length_i,
  input  wire logic [QCNT_W-1:0]    q_count_i,
  output thp_push_t                 push_o
);

  logic                     accept;
  logic                     ram_we;
  logic                     ram_re;
  logic [IDX_W-1:0]         ram_raddr;
  logic [LEN_W-1:0]         len_sat;
  logic [ENTRY_W-1:0]       ram_wdata;
  logic [ENTRY_W-1:0]       ram_rdata;
  logic                     rd_pend_q, rd_pend_d;
  logic                     rd_flush_q, rd_flush_d;
  logic [QCNT_W:0]          occupancy;

  // Count the lookup in flight so the queue can never overflow.
  assign occupancy  = {1'b0, q_count_i} + (QCNT_W + 1)'(rd_pend_q);
  assign in_stall_o = occupancy >= (QCNT_W + 1)'(QUEUE_DEPTH);
  assign accept     = in_valid_i && !in_stall_o;

  assign len_sat   = (entry_length_i > LEN_W'(MAX_CODE_BITS)) ? LEN_W'(MAX_CODE_BITS)
                                                               : entry_length_i;
  assign ram_wdata = {entry_code_i[MAX_CODE_BITS-1:0], len_sat};

  always_comb begin
    ram_we     = 1'b0;
    ram_re     = 1'b0;
    ram_raddr  = IDX_W'(TERMINATOR);
    rd_flush_d = 1'b0;
    case (thp_cmd_e'(cmd_i))
      CMD_ENCODE: begin
        ram_re    = accept;
        ram_raddr = IDX_W'(data_byte_i);
      end
      CMD_LOAD: begin
        ram_we = accept && (entry_index_i <= IDX_W'(TERMINATOR));
      end
      CMD_FLUSH: begin
        ram_re     = accept;
        rd_flush_d = 1'b1;
      end
      default: begin
        // unknown command: dropped
      end
    endcase
    rd_pend_d = ram_re;
  end

  thp_ram #(
    .DATA_W (ENTRY_W),
    .DEPTH  (TABLE_DEPTH)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (entry_index_i),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_pend_q  <= 1'b0;
      rd_flush_q <= 1'b0;
    end else begin
      rd_pend_q  <= rd_pend_d;
      rd_flush_q <= rd_flush_d;
    end
  end

  assign push_o.valid          = rd_pend_q;
  assign push_o.entry.is_flush = rd_flush_q;
  assign push_o.entry.code     = ram_rdata[ENTRY_W-1:LEN_W];
  assign push_o.entry.len      = ram_rdata[LEN_W-1:0];

  `THP_ASSERT_ALWAYS(a_no_rw_same_cycle, !(ram_we && ram_re), "table read and write together")
  `THP_ASSERT_NEXT(a_lookup_pushed, ram_re, push_o.valid, "lookup not pushed next cycle")

endmodule

`default_nettype wire

### design/thp_queue.sv
// Short FIFO of looked-up codes between the front end and the packer.
// Depends on thp_pkg.
`default_nettype none

`include "table_huffman_bit_packer_assert.svh"

module thp_queue
  import thp_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire thp_push_t         push_i,
  input  wire logic              pop_i,
  output logic                   valid_o,
  output thp_entry_t             head_o,
  output logic      [QCNT_W-1:0] count_o
);

  thp_entry_t        slot_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] count_q, count_d;
  logic              do_pop;

  assign do_pop  = pop_i && (count_q != '0);
  assign valid_o = count_q != '0;
  assign head_o  = slot_q[rd_ptr_q];
  assign count_o = count_q;

  always_comb begin
    wr_ptr_d = push_i.valid ? wr_ptr_q + QPTR_W'(1) : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + QPTR_W'(1) : rd_ptr_q;
    count_d  = count_q + QCNT_W'(push_i.valid) - QCNT_W'(do_pop);
  end

  always_ff @(posedge clk_i) begin
    if (push_i.valid) begin
      slot_q[wr_ptr_q] <= push_i.entry;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  `THP_ASSERT_IMPL(a_no_overflow, count_q == QCNT_W'(QUEUE_DEPTH), !push_i.valid, "queue overflow")
  `THP_ASSERT_IMPL(a_no_underflow, pop_i, count_q != '0, "pop from empty queue")

endmodule

`default_nettype wire

### design/thp_back.sv
// Packer: merges each queued code into the bit accumulator and emits bytes.
// Depends on thp_pkg; drives the output channel from its burst register.
`default_nettype none

`include "table_huffman_bit_packer_assert.svh"

module thp_back
  import thp_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       q_valid_i,
  input  wire thp_entry_t q_head_i,
  output logic            q_pop_o,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic [7:0]      out_byte_o,
  output logic            packet_end_o
);

  logic [ACC_W-1:0]   acc_q, acc_d;
  logic [PEND_W-1:0]  pend_q, pend_d;
  logic [BURST_W-1:0] burst_q, burst_d;
  logic [BCNT_W-1:0]  bcnt_q, bcnt_d;
  logic               bflush_q, bflush_d;

  logic               out_take;
  logic [VAL_W-1:0]   code_mask;
  logic [VAL_W-1:0]   val;
  logic [TOT_W-1:0]   total;
  logic [SH_W-1:0]    shamt;
  logic [BURST_W-1:0] aligned;
  logic [PEND_W-1:0]  rem;
  logic [VAL_W-1:0]   rem_mask;
  logic [BCNT_W-1:0]  full_bytes;
  logic [BCNT_W-1:0]  new_cnt;

  assign out_take = out_valid_o && !out_stall_i;
  assign q_pop_o  = q_valid_i &&
                    ((bcnt_q == '0) || ((bcnt_q == BCNT_W'(1)) && out_take));

  // Pending bits followed by the new code, right aligned.
  assign code_mask  = (VAL_W'(1) << q_head_i.len) - VAL_W'(1);
  assign val        = (VAL_W'(acc_q) << q_head_i.len) | (VAL_W'(q_head_i.code) & code_mask);
  assign total      = TOT_W'(pend_q) + TOT_W'(q_head_i.len);
  // Left align so the oldest bit lands in the top bit; the tail is zero padded.
  assign shamt      = SH_W'(BURST_W) - SH_W'(total);
  assign aligned    = BURST_W'(val) << shamt;
  assign rem        = total[PEND_W-1:0];
  assign rem_mask   = (VAL_W'(1) << rem) - VAL_W'(1);
  assign full_bytes = BCNT_W'(total / BYTE_BITS);
  assign new_cnt    = full_bytes + BCNT_W'(q_head_i.is_flush && (rem != '0));

  always_comb begin
    acc_d    = acc_q;
    pend_d   = pend_q;
    burst_d  = burst_q;
    bcnt_d   = bcnt_q;
    bflush_d = bflush_q;
    if (q_pop_o) begin
      burst_d  = aligned;
      bcnt_d   = new_cnt;
      bflush_d = q_head_i.is_flush;
      if (q_head_i.is_flush) begin
        acc_d  = '0;
        pend_d = '0;
      end else begin
        acc_d  = ACC_W'(val & rem_mask);
        pend_d = rem;
      end
    end else if (out_take) begin
      burst_d = burst_q << BYTE_BITS;
      bcnt_d  = bcnt_q - BCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    burst_q <= burst_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q    <= '0;
      pend_q   <= '0;
      bcnt_q   <= '0;
      bflush_q <= 1'b0;
    end else begin
      acc_q    <= acc_d;
      pend_q   <= pend_d;
      bcnt_q   <= bcnt_d;
      bflush_q <= bflush_d;
    end
  end

  assign out_valid_o  = bcnt_q != '0;
  assign out_byte_o   = burst_q[BURST_W-1 -: 8];
  assign packet_end_o = bflush_q && (bcnt_q == BCNT_W'(1));

  `THP_ASSERT_ALWAYS(a_acc_clean, (VAL_W'(acc_q) >> pend_q) == '0, "stray accumulator bits")
  `THP_ASSERT_NEXT(a_flush_clears, q_pop_o && q_head_i.is_flush, (acc_q == '0) && (pend_q == '0),
    "flush left bits pending")

endmodule

`default_nettype wire

### design/table_huffman_bit_packer.sv
// Top level of the table-driven Huffman bit packer.
// Depends on thp_pkg, thp_front, thp_queue, thp_back (and thp_ram below the front end).
`default_nettype none

// Static Huffman encoder with a loadable 257-entry code table. Each input
// transaction carries a command: encode (look up data_byte_i and append its
// code, MSB first), load (write entry entry_index_i with entry_code_i and
// entry_length_i; indexes above 256 are dropped, lengths above the maximum
// saturate) or flush (append the terminator code of entry 256, zero-pad the
// partial byte, mark the last byte with packet_end_o). Command 3 is dropped.
// Entries must be loaded before they are used; the table has no reset.
// Flow: the front end takes one transaction per clock whenever the
// four-entry code queue has room, and each lookup goes through the table
// RAM's registered read. The packer retires one queued code per cycle
// while no bytes wait; else it takes the next code as the last byte is
// taken. An encode gives at most 2 bytes, a flush at most 3. Loads and
// dropped commands finish in the front end and never reach the back.
// On its way out a code passes the table read register, a queue slot and
// the packer's burst register, which holds the byte at the output, so the
// input keeps flowing while the output is stalled until the queue fills.

module table_huffman_bit_packer
  import thp_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire logic [1:0]           cmd_i,
  input  wire logic [7:0]           data_byte_i,
  input  wire logic [IDX_W-1:0]     entry_index_i,
  input  wire logic [CODE_IN_W-1:0] entry_code_i,
  input  wire logic [LEN_W-1:0]     entry_length_i,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output logic [7:0]                out_byte_o,
  output logic                      packet_end_o
);

  thp_push_t         push;
  logic              q_valid;
  thp_entry_t        q_head;
  logic [QCNT_W-1:0] q_count;
  logic              q_pop;

  // Accept, table writes and lookups.
  thp_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .cmd_i          (cmd_i),
    .data_byte_i    (data_byte_i),
    .entry_index_i  (entry_index_i),
    .entry_code_i   (entry_code_i),
    .entry_length_i (entry_length_i),
    .q_count_i      (q_count),
    .push_o         (push)
  );

  // Decouples lookups from byte emission.
  thp_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .head_o  (q_head),
    .count_o (q_count)
  );

  // Bit accumulator and output bytes.
  thp_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_valid_i    (q_valid),
    .q_head_i     (q_head),
    .q_pop_o      (q_pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_byte_o   (out_byte_o),
    .packet_end_o (packet_end_o)
  );

endmodule

`default_nettype wire

### bench/tb_table_huffman_bit_packer.sv
`timescale 1ns / 100ps
// Self-checking bench for table_huffman_bit_packer: table loads, encodes and flushes.
// Needs thp_pkg and the block's RTL; the expected bytes come from a scoreboard class.

module tb_table_huffman_bit_packer;
  import thp_pkg::*;

  // Command 3 has no member in thp_cmd_e; the block must drop it.
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  localparam int unsigned CYCLE_LIMIT  = 200000;
  // Zero-length codes and empty flushes can still sit in the code queue
  // after the last byte has come out.
  localparam int unsigned SETTLE_TICKS = 16;
  localparam int unsigned HOLD_TICKS   = 150;

  typedef struct packed {
    logic [7:0] value;
    logic       last;
  } packed_byte_t;

  // Shadow of the code table and the bit accumulator. note_transaction()
  // is called for every accepted input transaction and queues the bytes it
  // must produce; check_byte() retires them in order.
  class huffman_scoreboard;
    logic [CODE_IN_W-1:0] code_mem [TABLE_DEPTH];
    logic [LEN_W-1:0]     len_mem  [TABLE_DEPTH];
    bit                   loaded   [TABLE_DEPTH];
    logic [7:0]           acc;
    int unsigned          nbits;
    packed_byte_t         expected_bytes [$];
    int unsigned          fail_count;

    function new();
      foreach (loaded[i]) begin
        loaded[i]   = 1'b0;
        code_mem[i] = '0;
        len_mem[i]  = '0;
      end
      acc        = '0;
      nbits      = 0;
      fail_count = 0;
    endfunction

    function bit has_entry(int unsigned idx);
      return loaded[idx];
    endfunction

    function int unsigned outstanding();
      return expected_bytes.size();
    endfunction

    // Append a code MSB first; every eighth bit completes a byte.
    function void shift_code(logic [CODE_IN_W-1:0] code, logic [LEN_W-1:0] len);
      int j;
      for (j = int'(len) - 1; j >= 0; j--) begin
        acc = {acc[6:0], code[j]};
        nbits++;
        if (nbits == BYTE_BITS) begin
          expected_bytes.push_back('{value: acc, last: 1'b0});
          acc   = '0;
          nbits = 0;
        end
      end
    endfunction

    function void note_transaction(logic [1:0] cmd, logic [7:0] data,
                                   logic [IDX_W-1:0] idx, logic [CODE_IN_W-1:0] code,
                                   logic [LEN_W-1:0] len);
      int unsigned  queued;
      packed_byte_t tail;
      case (cmd)
        CMD_ENCODE: shift_code(code_mem[data], len_mem[data]);
        CMD_LOAD: begin
          // Indexes past the terminator are dropped. Lengths cannot exceed
          // MAX_CODE_BITS at a 4-bit field, so no saturation shows here.
          if (idx <= TERMINATOR) begin
            code_mem[idx] = code;
            len_mem[idx]  = len;
            loaded[idx]   = 1'b1;
          end
        end
        CMD_FLUSH: begin
          queued = expected_bytes.size();
          shift_code(code_mem[TERMINATOR], len_mem[TERMINATOR]);
          if (nbits != 0) begin
            expected_bytes.push_back('{value: acc << (BYTE_BITS - nbits), last: 1'b0});
          end
          // Empty flush leaves nothing to mark.
          if (expected_bytes.size() > queued) begin
            tail      = expected_bytes.pop_back();
            tail.last = 1'b1;
            expected_bytes.push_back(tail);
          end
          acc   = '0;
          nbits = 0;
        end
        default: ;
      endcase
    endfunction

    function void check_byte(logic [7:0] got, logic got_last);
      packed_byte_t want;
      if (expected_bytes.size() == 0) begin
        $display("%0t: unexpected output byte %h packet_end %b", $time, got, got_last);
        fail_count++;
      end else begin
        want = expected_bytes.pop_front();
        if (got !== want.value) begin
          $display("%0t: out_byte expected %h, actual %h", $time, want.value, got);
          fail_count++;
        end
        if (got_last !== want.last) begin
          $display("%0t: packet_end expected %b, actual %b", $time, want.last, got_last);
          fail_count++;
        end
      end
    endfunction
  endclass

  logic                 clk_i          = 1'b0;
  logic                 rst_ni         = 1'b0;
  logic                 in_valid_i     = 1'b0;
  logic                 in_stall_o;
  logic [1:0]           cmd_i          = '0;
  logic [7:0]           data_byte_i    = '0;
  logic [IDX_W-1:0]     entry_index_i  = '0;
  logic [CODE_IN_W-1:0] entry_code_i   = '0;
  logic [LEN_W-1:0]     entry_length_i = '0;
  logic                 out_valid_o;
  logic                 out_stall_i    = 1'b0;
  logic [7:0]           out_byte_o;
  logic                 packet_end_o;

  huffman_scoreboard sb = new();

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned hold_request  = 0;
  int unsigned sent_items    = 0;   // every accepted input transaction
  int unsigned cycle_count   = 0;

  table_huffman_bit_packer dut (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_stall_o,
    .cmd_i,
    .data_byte_i,
    .entry_index_i,
    .entry_code_i,
    .entry_length_i,
    .out_valid_o,
    .out_stall_i,
    .out_byte_o,
    .packet_end_o
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // Watchdog: a hung handshake ends the run here.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("table_huffman_bit_packer: mismatch");
    $finish;
  end

  // Output side. A transaction is taken at the rising edge; the stall for
  // the next edge is chosen at the falling edge. A hold request from the
  // main sequence turns into a long stall counted down here.
  initial begin
    int unsigned hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i) begin
        sb.check_byte(out_byte_o, packet_end_o);
      end
      @(negedge clk_i);
      if (hold_request > 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        out_stall_i <= 1'b1;
        hold_left--;
      end else begin
        out_stall_i <= ($urandom_range(0, 99) < recv_idle_pct);
      end
    end
  end

  // Offer one input transaction and return once it is accepted. Idle
  // cycles before it carry junk payload with valid low. Valid is left high
  // so that back-to-back transactions follow without a gap.
  task automatic send_item(input logic [1:0] cmd, input logic [7:0] data,
                           input logic [IDX_W-1:0] idx, input logic [CODE_IN_W-1:0] code,
                           input logic [LEN_W-1:0] len);
    @(negedge clk_i);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i     <= 1'b0;
      cmd_i          <= 2'($urandom);
      data_byte_i    <= 8'($urandom);
      entry_index_i  <= IDX_W'($urandom);
      entry_code_i   <= CODE_IN_W'($urandom);
      entry_length_i <= LEN_W'($urandom);
      @(negedge clk_i);
    end
    in_valid_i     <= 1'b1;
    cmd_i          <= cmd;
    data_byte_i    <= data;
    entry_index_i  <= idx;
    entry_code_i   <= code;
    entry_length_i <= len;
    do @(posedge clk_i); while (in_stall_o);
    sent_items++;
    sb.note_transaction(cmd, data, idx, code, len);
  endtask

  task automatic load_entry(input int unsigned idx, input logic [CODE_IN_W-1:0] code,
                            input logic [LEN_W-1:0] len);
    send_item(CMD_LOAD, 8'($urandom), IDX_W'(idx), code, len);
  endtask

  task automatic encode_byte(input logic [7:0] data);
    send_item(CMD_ENCODE, data, IDX_W'($urandom), CODE_IN_W'($urandom), LEN_W'($urandom));
  endtask

  task automatic flush_packet();
    send_item(CMD_FLUSH, 8'($urandom), IDX_W'($urandom), CODE_IN_W'($urandom),
              LEN_W'($urandom));
  endtask

  // Drop valid and let every expected byte come out, then give queued
  // codes that produce no bytes time to retire.
  task automatic wait_drained();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk_i);
    repeat (SETTLE_TICKS) @(posedge clk_i);
  endtask

  // One random transaction. Table entries are loaded before their first
  // use, since an unwritten entry has no defined contents.
  task automatic random_item();
    int unsigned pick;
    logic [7:0]  data;
    pick = $urandom_range(0, 99);
    if (pick < 55) begin
      data = 8'($urandom);
      if (!sb.has_entry(data)) begin
        load_entry(data, CODE_IN_W'($urandom), LEN_W'($urandom));
      end
      encode_byte(data);
    end else if (pick < 72) begin
      // Terminator rewrites get extra weight so flush lengths vary.
      load_entry(($urandom_range(0, 3) == 0) ? TERMINATOR : $urandom_range(0, TERMINATOR),
                 CODE_IN_W'($urandom), LEN_W'($urandom));
    end else if (pick < 84) begin
      if (!sb.has_entry(TERMINATOR)) begin
        load_entry(TERMINATOR, CODE_IN_W'($urandom), LEN_W'($urandom));
      end
      flush_packet();
    end else if (pick < 92) begin
      load_entry($urandom_range(TERMINATOR + 1, (1 << IDX_W) - 1),
                 CODE_IN_W'($urandom), LEN_W'($urandom));
    end else begin
      send_item(CMD_UNUSED, 8'($urandom), IDX_W'($urandom), CODE_IN_W'($urandom),
                LEN_W'($urandom));
    end
  endtask

  task automatic random_items(input int unsigned count);
    int unsigned goal;
    goal = sent_items + count;
    while (sent_items < goal) random_item();
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed part, no idling.
    // Zero-length terminator with nothing pending: the flush is empty.
    load_entry(TERMINATOR, '0, '0);
    flush_packet();
    load_entry(0, 15'h7FFF, 4'd15);
    load_entry(255, 15'h0000, 4'd15);
    load_entry(1, 15'h7FFF, 4'd0);       // zero-length code
    load_entry(2, 15'h7FFF, 4'd3);       // only the low three bits count
    load_entry(257, 15'h1234, 4'd5);     // out of range, dropped
    load_entry(511, 15'h7FFF, 4'd15);    // out of range, dropped
    send_item(CMD_UNUSED, 8'hFF, 9'h1FF, 15'h7FFF, 4'hF);
    encode_byte(8'd0);                   // one byte out, seven bits pending
    encode_byte(8'd1);                   // nothing
    encode_byte(8'd0);                   // two bytes
    encode_byte(8'd255);                 // two bytes, five pending
    // Longest terminator on top of five pending bits: three bytes.
    load_entry(TERMINATOR, 15'h7FFF, 4'd15);
    flush_packet();
    flush_packet();                      // terminator plus pad byte
    load_entry(TERMINATOR, 15'h00A5, 4'd8);
    flush_packet();                      // one whole byte, no padding
    load_entry(TERMINATOR, 15'h5555, 4'd0);
    encode_byte(8'd2);
    flush_packet();                      // pad byte alone
    wait_drained();

    // Random part in three idling phases.
    send_idle_pct = 23;
    recv_idle_pct = 76;
    random_items(140);
    wait_drained();

    send_idle_pct = 76;
    recv_idle_pct = 23;
    random_items(140);
    wait_drained();

    // Long output stall while input keeps coming: the code queue fills
    // and in_stall_o must hold the sender off.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_request  = HOLD_TICKS;
    random_items(130);
    wait_drained();

    if (sb.fail_count == 0) begin
      $display("table_huffman_bit_packer: match");
    end else begin
      $display("table_huffman_bit_packer: mismatch");
    end
    $finish;
  end

endmodule
